>>> hw/rtl/des_pkg.sv
`default_nettype none
package des_pkg;

  localparam int unsigned Rounds = 16;

  localparam logic [0:63][6:0] TabIp = '{
    58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
    62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
    57,49,41,33,25,17,9,1, 59,51,43,35,27,19,11,3,
    61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7};
  localparam logic [0:63][6:0] TabFp = '{
    40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
    38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
    36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
    34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25};
  localparam logic [0:47][5:0] TabE = '{
    32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
    16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29, 28,29,30,31,32,1};
  localparam logic [0:31][5:0] TabP = '{
    16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
    2,8,24,14,32,27,3,9, 19,13,30,6,22,11,4,25};
  localparam logic [0:55][6:0] TabPc1 = '{
    57,49,41,33,25,17,9, 1,58,50,42,34,26,18, 10,2,59,51,43,35,27,
    19,11,3,60,52,44,36, 63,55,47,39,31,23,15, 7,62,54,46,38,30,22,
    14,6,61,53,45,37,29, 21,13,5,28,20,12,4};
  localparam logic [0:47][5:0] TabPc2 = '{
    14,17,11,24,1,5, 3,28,15,6,21,10, 23,19,12,4,26,8, 16,7,27,20,13,2,
    41,52,31,37,47,55, 30,40,51,45,33,48, 44,49,39,56,34,53, 46,42,50,36,29,32};
  localparam logic [0:15][1:0] TabRot = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};
  localparam logic [0:7][0:63][3:0] TabS = '{
    '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7, 0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
      4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0, 15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
    '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10, 3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
      0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15, 13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
    '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8, 13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
      13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7, 1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
    '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15, 13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
      10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4, 3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
    '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9, 14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
      4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14, 11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
    '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11, 10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
      9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6, 4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
    '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1, 13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
      1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2, 6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
    '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7, 1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
      7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8, 2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

  localparam logic [0:0] CfgKey  = 1'b0;
  localparam logic [0:0] CfgMode = 1'b1;

  function automatic logic [63:0] perm_ip(input logic [63:0] x);
    logic [63:0] r;
    for (int i = 0; i < 64; i++) r[63-i] = x[64 - 32'(TabIp[i])];
    return r;
  endfunction

  function automatic logic [63:0] perm_fp(input logic [63:0] x);
    logic [63:0] r;
    for (int i = 0; i < 64; i++) r[63-i] = x[64 - 32'(TabFp[i])];
    return r;
  endfunction

  function automatic logic [55:0] perm_pc1(input logic [63:0] x);
    logic [55:0] r;
    for (int i = 0; i < 56; i++) r[55-i] = x[64 - 32'(TabPc1[i])];
    return r;
  endfunction

  function automatic logic [47:0] perm_pc2(input logic [55:0] x);
    logic [47:0] r;
    for (int i = 0; i < 48; i++) r[47-i] = x[56 - 32'(TabPc2[i])];
    return r;
  endfunction

  function automatic logic [27:0] rotl28(input logic [27:0] x, input logic [1:0] n);
    return (n == 2'd1) ? {x[26:0], x[27]} : {x[25:0], x[27:26]};
  endfunction

  // One Feistel round function: E, key xor, S-boxes, P.
  function automatic logic [31:0] feistel(input logic [31:0] r, input logic [47:0] k);
    logic [47:0] x;
    logic [31:0] s;
    logic [31:0] p;
    logic [5:0]  b;
    for (int i = 0; i < 48; i++) x[47-i] = r[32 - 32'(TabE[i])];
    x = x ^ k;
    for (int i = 0; i < 8; i++) begin
      b = x[42-6*i +: 6];
      s[28-4*i +: 4] = TabS[i][{b[5], b[0], b[4:1]}];
    end
    for (int i = 0; i < 32; i++) p[31-i] = s[32 - 32'(TabP[i])];
    return p;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/des_block_cipher.sv
// Channel | Signals                           | Direction
// in      | in_valid/in_ready, data_block_i   | upstream -> block
// out     | out_valid/out_ready, result_block_o | block -> downstream
// cfg     | cfg_we_i, cfg_idx_i, cfg_data_i   | write only
//
// One item per cycle while the output is not stalled. Pipeline: IP stage, sixteen
// round stages (one Feistel round each), then FP into the output register.
// Round keys are plain wiring from the key register (PC-1, fixed rotations,
// PC-2), valid in the cycle after a write; the user must write config only
// while idle, not enforced by the block. Reset clears valid bits and the config
// registers. A stall freezes the whole pipe (global enable); nothing is lost.
`default_nettype none
module des_block_cipher (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [63:0] data_block_i,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      result_block_o,
  input  wire logic        cfg_we_i,
  input  wire logic [0:0]  cfg_idx_i,
  input  wire logic [63:0] cfg_data_i
);
  import des_pkg::*;

  logic [63:0] key_q;
  logic        mode_q;
  // Round keys, encrypt order, built from the key by plain wiring.
  logic [0:15][47:0] rk;
  logic [0:16][55:0] cd;

  always_comb begin
    cd[0] = perm_pc1(key_q);
    for (int i = 0; i < 16; i++) begin
      cd[i+1] = {rotl28(cd[i][55:28], TabRot[i]), rotl28(cd[i][27:0], TabRot[i])};
      rk[i] = perm_pc2(cd[i+1]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q  <= '0;
      mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgKey:  key_q  <= cfg_data_i;
        CfgMode: mode_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Pipe: stage 0 after IP, stage s after round s, output after FP.
  logic [0:16]       vld_q;
  logic [0:16][63:0] lr_q;
  logic              out_vld_q;
  logic [63:0]       out_q;
  logic              en;

  assign en       = !out_vld_q || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q     <= {in_valid, vld_q[0:15]};
      out_vld_q <= vld_q[16];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      lr_q[0] <= perm_ip(data_block_i);
      for (int s = 0; s < 16; s++) begin
        lr_q[s+1] <= {lr_q[s][31:0],
                      lr_q[s][63:32] ^ feistel(lr_q[s][31:0],
                                               mode_q ? rk[15-s] : rk[s])};
      end
      out_q <= perm_fp({lr_q[16][31:0], lr_q[16][63:32]});
    end
  end

  assign out_valid      = out_vld_q;
  assign result_block_o = out_q;

endmodule
`default_nettype wire

>>> hw/rtl/des_checker.sv
`default_nettype none
module des_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [63:0] result_block_o
);
  // Output held while stalled.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(result_block_o)) else $error("out");
  // Ready follows the output side.
  a_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid |-> in_ready) else $error("rdy");
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |-> !in_ready) else $error("stall");
endmodule

bind des_block_cipher des_checker u_chk (.*);
`default_nettype wire
